### rtl/contiguous_frame_allocator_defines.svh
// assertion macros used by the frame allocator controller
// expects clk and rst_n in the scope where a macro is used
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define CFA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define CFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cfa_pkg.sv
// shared constants, frame state codes and controller/datapath structs
// for the contiguous frame allocator; no dependencies
package cfa_pkg;

    localparam int MAX_FRAMES_DEF = 1024;

    localparam int BASE_W  = 20;
    localparam int POOL_W  = 11;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 11;
    localparam int FS_W    = 2;

    localparam logic [POOL_W-1:0] POOL_RST = 11'd1024;

    // per-frame state codes
    localparam logic [FS_W-1:0] FS_FREE  = 2'd0;
    localparam logic [FS_W-1:0] FS_HEAD  = 2'd1;
    localparam logic [FS_W-1:0] FS_ALLOC = 2'd2;
    localparam logic [FS_W-1:0] FS_INACC = 2'd3;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK    = 2'd2;

    // configuration register indexes
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_POOL = 1'b1;

    typedef struct packed {
        logic            capture;
        logic            scan_alloc;
        logic            scan_rel;
        logic            rd_step;
        logic            flush;
        logic            run_step;
        logic            inacc_hold;
        logic            win_mark;
        logic            win_alloc;
        logic            win_rel;
        logic            win_rel_end;
        logic            wr_step;
        logic            wr_here;
        logic            wr_rel;
        logic [FS_W-1:0] wr_code;
        logic            clear_step;
        logic            resp_load;
        logic            resp_ok;
        logic            resp_alloc;
    } cfa_cmd_t;

    typedef struct packed {
        logic            d_valid;
        logic [FS_W-1:0] d_state;
        logic            scan_end;
        logic            run_hit;
        logic            win_done;
        logic            clr_last;
        logic            kind_alloc;
        logic            kind_rel;
        logic            kind_mark;
        logic            in_pool;
        logic            bad_count;
        logic            resp_room;
    } cfa_sts_t;

endpackage

### rtl/cfa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module cfa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/cfa_datapath.sv
// frame map, scan and write pointers, config and result registers
// depends on cfa_pkg and cfa_ram
module cfa_datapath #(
    parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [cfa_pkg::BASE_W-1:0]   cfg_data,
    input  logic [cfa_pkg::KIND_W-1:0]   kind,
    input  logic [cfa_pkg::BASE_W-1:0]   frame,
    input  logic [cfa_pkg::COUNT_W-1:0]  count,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [cfa_pkg::BASE_W-1:0]   start_frame,
    output logic                         ok,
    input  cfa_pkg::cfa_cmd_t            cmd,
    output cfa_pkg::cfa_sts_t            sts
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int PW = $clog2(MAX_FRAMES + 2048) + 1;
    localparam int CW = (PW > cfa_pkg::BASE_W) ? PW : cfa_pkg::BASE_W;

    logic [cfa_pkg::BASE_W-1:0]  base_reg, base_next;
    logic [cfa_pkg::POOL_W-1:0]  pool_reg, pool_next;
    logic [cfa_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [cfa_pkg::BASE_W-1:0]  frame_reg, frame_next;
    logic [cfa_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [PW-1:0]               scan_reg, scan_next;
    logic [PW-1:0]               dpos_reg, dpos_next;
    logic                        dvalid_reg, dvalid_next;
    logic [PW-1:0]               run_reg, run_next;
    logic [PW-1:0]               inacc_reg, inacc_next;
    logic [PW-1:0]               wpos_reg, wpos_next;
    logic [PW-1:0]               wend_reg, wend_next;
    logic [PW-1:0]               found_reg, found_next;
    logic                        out_valid_reg, out_valid_next;
    logic [cfa_pkg::BASE_W-1:0]  start_reg, start_next;
    logic                        ok_reg, ok_next;

    logic [PW-1:0]               size;
    logic [cfa_pkg::BASE_W-1:0]  rel_full;
    logic [PW-1:0]               rel_pos;
    logic [PW-1:0]               count_pos;
    logic [PW-1:0]               mark_sum;
    logic [PW-1:0]               mark_end;
    logic [PW-1:0]               run_inc;
    logic [PW-1:0]               hit_start;
    logic                        in_pool;
    logic                        scan_end;
    logic                        rd_issue;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [cfa_pkg::FS_W-1:0]    ram_wdata;
    logic [cfa_pkg::FS_W-1:0]    ram_rdata;

    cfa_ram #(
        .WIDTH (cfa_pkg::FS_W),
        .DEPTH (MAX_FRAMES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_issue),
        .raddr (scan_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // pool size in use is clipped to the map depth
    assign size = (PW'(pool_reg) > PW'(MAX_FRAMES)) ? PW'(MAX_FRAMES) : PW'(pool_reg);

    assign rel_full  = frame_reg - base_reg;
    assign rel_pos   = PW'(rel_full);
    assign in_pool   = (frame_reg >= base_reg) && (CW'(rel_full) < CW'(size));
    assign count_pos = PW'(count_reg);
    assign mark_sum  = rel_pos + count_pos;
    assign mark_end  = (mark_sum > size) ? size : mark_sum;
    assign run_inc   = run_reg + PW'(1);
    assign hit_start = dpos_reg + PW'(1) - count_pos;
    assign scan_end  = (scan_reg >= size);
    assign rd_issue  = cmd.rd_step && !scan_end;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wpos_reg[AW-1:0];
        ram_wdata = cmd.wr_code;
        if (cmd.clear_step)
        begin
            ram_we    = 1'b1;
            ram_wdata = cfa_pkg::FS_FREE;
        end
        else if (cmd.wr_step)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.wr_here)
        begin
            ram_we    = 1'b1;
            ram_waddr = dpos_reg[AW-1:0];
        end
        else if (cmd.wr_rel)
        begin
            ram_we    = 1'b1;
            ram_waddr = rel_pos[AW-1:0];
        end
    end

    always_comb
    begin
        base_next      = base_reg;
        pool_next      = pool_reg;
        kind_next      = kind_reg;
        frame_next     = frame_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        dpos_next      = dpos_reg;
        dvalid_next    = rd_issue;
        run_next       = run_reg;
        inacc_next     = inacc_reg;
        wpos_next      = wpos_reg;
        wend_next      = wend_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        start_next     = start_reg;
        ok_next        = ok_reg;

        if (cfg_we)
        begin
            if (cfg_index == cfa_pkg::CFG_BASE)
            begin
                base_next = cfg_data;
            end
            else
            begin
                pool_next = cfg_data[cfa_pkg::POOL_W-1:0];
            end
        end

        if (cmd.capture)
        begin
            kind_next  = kind;
            frame_next = frame;
            count_next = count;
        end

        if (rd_issue)
        begin
            scan_next = scan_reg + PW'(1);
            dpos_next = scan_reg;
        end
        if (cmd.scan_alloc)
        begin
            scan_next = '0;
            run_next  = '0;
        end
        if (cmd.scan_rel)
        begin
            scan_next = rel_pos + PW'(1);
        end
        if (cmd.capture || cmd.scan_alloc || cmd.scan_rel || cmd.flush)
        begin
            dvalid_next = 1'b0;
        end

        if (cmd.run_step)
        begin
            run_next = (ram_rdata == cfa_pkg::FS_FREE) ? run_inc : '0;
        end
        if (cmd.inacc_hold)
        begin
            inacc_next = dpos_reg;
        end

        if (cmd.clear_step || cmd.wr_step)
        begin
            wpos_next = wpos_reg + PW'(1);
        end
        if (cmd.win_mark)
        begin
            wpos_next = rel_pos;
            wend_next = mark_end;
        end
        if (cmd.win_alloc)
        begin
            wpos_next  = hit_start;
            wend_next  = dpos_reg + PW'(1);
            found_next = hit_start;
        end
        if (cmd.win_rel)
        begin
            wpos_next = inacc_reg;
            wend_next = dpos_reg;
        end
        if (cmd.win_rel_end)
        begin
            wpos_next = inacc_reg;
            wend_next = size;
        end

        if (cmd.resp_load)
        begin
            out_valid_next = 1'b1;
            ok_next        = cmd.resp_ok;
            start_next     = cmd.resp_alloc ?
                             (base_reg + cfa_pkg::BASE_W'(found_reg)) : '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            pool_reg      <= cfa_pkg::POOL_RST;
            dvalid_reg    <= 1'b0;
            wpos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            pool_reg      <= pool_next;
            dvalid_reg    <= dvalid_next;
            wpos_reg      <= wpos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        frame_reg <= frame_next;
        count_reg <= count_next;
        scan_reg  <= scan_next;
        dpos_reg  <= dpos_next;
        run_reg   <= run_next;
        inacc_reg <= inacc_next;
        wend_reg  <= wend_next;
        found_reg <= found_next;
        start_reg <= start_next;
        ok_reg    <= ok_next;
    end

    always_comb
    begin
        sts.d_valid    = dvalid_reg;
        sts.d_state    = ram_rdata;
        sts.scan_end   = scan_end;
        sts.run_hit    = dvalid_reg && (ram_rdata == cfa_pkg::FS_FREE)
                         && (run_inc == count_pos);
        sts.win_done   = (wpos_reg >= wend_reg);
        sts.clr_last   = (wpos_reg == PW'(MAX_FRAMES - 1));
        sts.kind_alloc = (kind_reg == cfa_pkg::KIND_ALLOC);
        sts.kind_rel   = (kind_reg == cfa_pkg::KIND_RELEASE);
        sts.kind_mark  = (kind_reg == cfa_pkg::KIND_MARK);
        sts.in_pool    = in_pool;
        sts.bad_count  = (count_reg == '0) || (count_pos > size);
        sts.resp_room  = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign start_frame = start_reg;
    assign ok          = ok_reg;

endmodule

### rtl/cfa_ctrl.sv
// sequencing state machine for clear, allocate, release and mark
// depends on cfa_pkg and contiguous_frame_allocator_defines.svh
`include "contiguous_frame_allocator_defines.svh"

module cfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cfa_pkg::cfa_sts_t sts,
    output cfa_pkg::cfa_cmd_t cmd
);

    localparam logic [3:0] S_CLEAR      = 4'd0;
    localparam logic [3:0] S_IDLE       = 4'd1;
    localparam logic [3:0] S_DECODE     = 4'd2;
    localparam logic [3:0] S_ALLOC_SCAN = 4'd3;
    localparam logic [3:0] S_ALLOC_HEAD = 4'd4;
    localparam logic [3:0] S_ALLOC_FILL = 4'd5;
    localparam logic [3:0] S_REL_SCAN   = 4'd6;
    localparam logic [3:0] S_REL_INACC  = 4'd7;
    localparam logic [3:0] S_REL_FILL   = 4'd8;
    localparam logic [3:0] S_MARK_FILL  = 4'd9;
    localparam logic [3:0] S_RESP_FAIL  = 4'd10;
    localparam logic [3:0] S_RESP_OK    = 4'd11;
    localparam logic [3:0] S_RESP_ALLOC = 4'd12;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_code = cfa_pkg::FS_FREE;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                if (sts.kind_alloc)
                begin
                    if (sts.bad_count)
                    begin
                        state_next = S_RESP_FAIL;
                    end
                    else
                    begin
                        cmd.scan_alloc = 1'b1;
                        state_next     = S_ALLOC_SCAN;
                    end
                end
                else if (sts.kind_rel && sts.in_pool)
                begin
                    // free the named frame and start walking from the next one
                    cmd.scan_rel = 1'b1;
                    cmd.wr_rel   = 1'b1;
                    state_next   = S_REL_SCAN;
                end
                else if (sts.kind_mark && sts.in_pool)
                begin
                    cmd.win_mark = 1'b1;
                    state_next   = S_MARK_FILL;
                end
                else
                begin
                    state_next = S_RESP_FAIL;
                end
            end

            S_ALLOC_SCAN:
            begin
                cmd.rd_step = 1'b1;
                if (sts.d_valid)
                begin
                    cmd.run_step = 1'b1;
                    if (sts.run_hit)
                    begin
                        cmd.win_alloc = 1'b1;
                        cmd.flush     = 1'b1;
                        state_next    = S_ALLOC_HEAD;
                    end
                end
                else if (sts.scan_end)
                begin
                    state_next = S_RESP_FAIL;
                end
            end

            S_ALLOC_HEAD:
            begin
                cmd.wr_step = 1'b1;
                cmd.wr_code = cfa_pkg::FS_HEAD;
                state_next  = S_ALLOC_FILL;
            end

            S_ALLOC_FILL:
            begin
                if (sts.win_done)
                begin
                    state_next = S_RESP_ALLOC;
                end
                else
                begin
                    cmd.wr_step = 1'b1;
                    cmd.wr_code = cfa_pkg::FS_ALLOC;
                end
            end

            S_REL_SCAN:
            begin
                cmd.rd_step = 1'b1;
                if (sts.d_valid)
                begin
                    if (sts.d_state == cfa_pkg::FS_ALLOC)
                    begin
                        cmd.wr_here = 1'b1;
                    end
                    else if (sts.d_state == cfa_pkg::FS_INACC)
                    begin
                        cmd.inacc_hold = 1'b1;
                        state_next     = S_REL_INACC;
                    end
                    else
                    begin
                        cmd.flush  = 1'b1;
                        state_next = S_RESP_OK;
                    end
                end
                else if (sts.scan_end)
                begin
                    state_next = S_RESP_OK;
                end
            end

            S_REL_INACC:
            begin
                // look past the inaccessible run before deciding to free it
                cmd.rd_step = 1'b1;
                if (sts.d_valid)
                begin
                    if (sts.d_state == cfa_pkg::FS_ALLOC)
                    begin
                        cmd.flush  = 1'b1;
                        state_next = S_RESP_OK;
                    end
                    else if (sts.d_state != cfa_pkg::FS_INACC)
                    begin
                        cmd.flush   = 1'b1;
                        cmd.win_rel = 1'b1;
                        state_next  = S_REL_FILL;
                    end
                end
                else if (sts.scan_end)
                begin
                    cmd.win_rel_end = 1'b1;
                    state_next      = S_REL_FILL;
                end
            end

            S_REL_FILL:
            begin
                if (sts.win_done)
                begin
                    state_next = S_RESP_OK;
                end
                else
                begin
                    cmd.wr_step = 1'b1;
                    cmd.wr_code = cfa_pkg::FS_FREE;
                end
            end

            S_MARK_FILL:
            begin
                if (sts.win_done)
                begin
                    state_next = S_RESP_OK;
                end
                else
                begin
                    cmd.wr_step = 1'b1;
                    cmd.wr_code = cfa_pkg::FS_INACC;
                end
            end

            S_RESP_FAIL:
            begin
                if (sts.resp_room)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_RESP_OK:
            begin
                if (sts.resp_room)
                begin
                    cmd.resp_load = 1'b1;
                    cmd.resp_ok   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_RESP_ALLOC:
            begin
                if (sts.resp_room)
                begin
                    cmd.resp_load  = 1'b1;
                    cmd.resp_ok    = 1'b1;
                    cmd.resp_alloc = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `CFA_ASSERT_NEXT(a_accept_decode, in_valid && in_ready, state_reg == S_DECODE, "no decode")
    `CFA_ASSERT_SAME(a_resp_room, cmd.resp_load, sts.resp_room, "result overwritten")
    `CFA_ASSERT_SAME(a_idle_no_read, state_reg == S_IDLE, !sts.d_valid, "stale read in idle")

endmodule

### rtl/contiguous_frame_allocator.sv
// First-fit contiguous frame allocator, top level.
// Channels: input words (kind, frame, count) and result words (start_frame, ok),
// both valid/ready; plus a write-only config port (cfg_we, cfg_index, cfg_data)
// holding base_frame (index 0) and pool_frames (index 1).
// One result word per input word; the next word can be taken in the cycle after a
// result is loaded. Work is one item at a time through a single
// 2-bit-per-frame map RAM with one read and one write port:
//   allocate: scans from frame 0 for a free run, one map entry read per cycle,
//             then writes the run as a head frame and allocated frames
//   release:  frames walked, plus frames freed after an inaccessible run
//   mark:     writes the frames marked
//   failures (bad count, frame out of pool, unused kind): no map access
// After reset every map entry is swept to free, one entry per cycle;
// no input word is taken during the sweep, config writes are.
// The result register frees the core from the receiver: a new word is taken
// while a result waits, and the core only stalls when the next result is ready
// and the previous one has still not been taken.
// depends on cfa_pkg, cfa_ctrl and cfa_datapath
module contiguous_frame_allocator #(
    parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [cfa_pkg::BASE_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cfa_pkg::KIND_W-1:0]   kind,
    input  logic [cfa_pkg::BASE_W-1:0]   frame,
    input  logic [cfa_pkg::COUNT_W-1:0]  count,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cfa_pkg::BASE_W-1:0]   start_frame,
    output logic                         ok
);

    cfa_pkg::cfa_cmd_t cmd;
    cfa_pkg::cfa_sts_t sts;

    cfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cfa_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .frame       (frame),
        .count       (count),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .start_frame (start_frame),
        .ok          (ok),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
